// ----- rtl/enorm_pkg.sv -----
// Types and constants shared by the error norm accumulator modules.
// No dependencies; every other file imports this package.
`default_nettype none

package enorm_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned CountW   = 17;
  localparam int unsigned SkipW    = 15;
  localparam int unsigned AbsSumW  = 49;
  localparam int unsigned SqW      = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MaxCells = 65536;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCellCount,
    CfgBoundarySkip,
    CfgRadiusEnable,
    CfgRadiusLimit
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FinIdle,
    FinDivide,
    FinRoot,
    FinDone
  } fin_state_e;

  typedef struct packed {
    logic signed [DataW-1:0] position;
    logic signed [DataW-1:0] reference_value;
    logic signed [DataW-1:0] computed_value;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0]  mean_abs_error;
    logic [DataW-1:0]  rms_error;
    logic [DataW-1:0]  max_abs_error;
    logic [CountW-1:0] masked_cells;
    logic              no_masked_cells;
    logic              no_interior_cells;
  } out_item_t;

  // One classified cell on its way from the front to the back.
  typedef struct packed {
    logic [DiffW-1:0]  diff_mag;
    logic              interior;
    logic              passes;
    logic              last;
    logic [CountW-1:0] interior_cnt;
  } cell_t;

  // Accumulator snapshot handed to the closing unit on the last cell.
  typedef struct packed {
    logic [AbsSumW-1:0] abs_sum;
    logic [SqW-1:0]     square_sum;
    logic [DiffW-1:0]   largest_abs;
    logic [CountW-1:0]  masked_count;
    logic [CountW-1:0]  interior_cnt;
  } snap_t;

endpackage

`default_nettype wire

// ----- rtl/enorm_front.sv -----
// Front part: configuration registers, cell index counter and classification.
// Depends on enorm_pkg.
`default_nettype none

module enorm_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_wr_i,
  input  wire logic [enorm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [enorm_pkg::DataW-1:0]     cfg_data_i,
  input  wire logic                            accept_i,
  input  wire enorm_pkg::in_item_t             item_i,
  output enorm_pkg::cell_t                     cell_o
);
  import enorm_pkg::*;

  localparam logic [CountW-1:0] MaxCnt = CountW'(MaxCells);
  localparam logic [CountW-1:0] OneCnt = CountW'(1);

  logic [CountW-1:0] cell_count_q;
  logic [SkipW-1:0]  boundary_skip_q;
  logic              radius_enable_q;
  logic [DataW-1:0]  radius_limit_q;
  logic [CountW-1:0] cell_index_q, cell_index_d;

  logic [CountW-1:0]  count;
  logic [CountW:0]    idx_plus_skip;
  logic [SkipW:0]     twice_skip;
  logic signed [DiffW-1:0] diff;
  logic [DataW-1:0]   pos_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q    <= OneCnt;
      boundary_skip_q <= '0;
      radius_enable_q <= 1'b0;
      radius_limit_q  <= '1;
    end else if (cfg_wr_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgCellCount:    cell_count_q    <= cfg_data_i[CountW-1:0];
        CfgBoundarySkip: boundary_skip_q <= cfg_data_i[SkipW-1:0];
        CfgRadiusEnable: radius_enable_q <= cfg_data_i[0];
        CfgRadiusLimit:  radius_limit_q  <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  always_comb begin
    // Clamp the run length to one through the largest grid.
    if (cell_count_q == '0) begin
      count = OneCnt;
    end else if (cell_count_q > MaxCnt) begin
      count = MaxCnt;
    end else begin
      count = cell_count_q;
    end

    idx_plus_skip = {1'b0, cell_index_q} + {{(CountW+1-SkipW){1'b0}}, boundary_skip_q};
    twice_skip    = {boundary_skip_q, 1'b0};
    diff    = DiffW'(item_i.reference_value) - DiffW'(item_i.computed_value);
    pos_mag = item_i.position[DataW-1] ? DataW'(-item_i.position) : DataW'(item_i.position);

    cell_o.diff_mag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    cell_o.interior = (cell_index_q >= CountW'(boundary_skip_q)) &&
                      (idx_plus_skip < {1'b0, count});
    cell_o.passes   = !radius_enable_q || (pos_mag < radius_limit_q);
    cell_o.last     = cell_index_q >= (count - OneCnt);
    cell_o.interior_cnt = (count > CountW'(twice_skip)) ? (count - CountW'(twice_skip)) : '0;

    cell_index_d = cell_o.last ? '0 : cell_index_q + OneCnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_index_q <= '0;
    end else if (accept_i) begin
      cell_index_q <= cell_index_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/enorm_fifo.sv -----
// Short queue of classified cells between front and back.
// Depends on enorm_pkg for the entry type.
`default_nettype none

module enorm_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire enorm_pkg::cell_t  wr_data_i,
  output logic                   full_o,
  input  wire logic              rd_i,
  output enorm_pkg::cell_t       rd_data_o,
  output logic                   nonempty_o
);
  import enorm_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cell_t            entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o     = cnt_q == CntW'(Depth);
  assign nonempty_o = cnt_q != '0;
  assign rd_data_o  = entries_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/enorm_back.sv -----
// Back part: squares the difference, then updates the saturating accumulators.
// Depends on enorm_pkg; hands a snapshot to enorm_final on the last cell.
`default_nettype none

module enorm_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_nonempty_i,
  input  wire enorm_pkg::cell_t  q_data_i,
  output logic                   q_rd_o,
  input  wire logic              fin_idle_i,
  output logic                   start_o,
  output enorm_pkg::snap_t       snap_o
);
  import enorm_pkg::*;

  localparam logic [AbsSumW-1:0] AbsSumMax = '1;

  logic            s1_valid_q;
  cell_t           s1_q;
  logic [SqW-1:0]  sq_q, sq_d;
  logic            consume;

  logic [AbsSumW-1:0] abs_sum_q;
  logic [SqW-1:0]     square_sum_q;
  logic [DiffW-1:0]   largest_q;
  logic [CountW-1:0]  masked_q;

  logic [SqW:0]       sq_add;
  logic [AbsSumW:0]   abs_add;
  logic               upd;
  snap_t              next;

  // Stall the last cell only while the closing unit is still busy.
  assign consume = s1_valid_q && !(s1_q.last && !fin_idle_i);
  assign q_rd_o  = q_nonempty_i && (!s1_valid_q || consume);
  assign start_o = consume && s1_q.last;
  assign snap_o  = next;

  always_comb begin
    if (q_data_i.diff_mag[DiffW-1]) begin
      sq_d = '1;
    end else begin
      sq_d = SqW'(q_data_i.diff_mag[DataW-1:0]) * SqW'(q_data_i.diff_mag[DataW-1:0]);
    end
  end

  always_comb begin
    upd     = s1_q.interior && s1_q.passes;
    sq_add  = {1'b0, square_sum_q} + {1'b0, sq_q};
    abs_add = {1'b0, abs_sum_q} + (AbsSumW+1)'(s1_q.diff_mag);

    next.square_sum   = !s1_q.interior ? square_sum_q :
                        (sq_add[SqW] ? '1 : sq_add[SqW-1:0]);
    next.abs_sum      = !upd ? abs_sum_q :
                        (abs_add[AbsSumW] ? AbsSumMax : abs_add[AbsSumW-1:0]);
    next.largest_abs  = (upd && (s1_q.diff_mag > largest_q)) ? s1_q.diff_mag : largest_q;
    next.masked_count = (upd && (masked_q != '1)) ? masked_q + CountW'(1) : masked_q;
    next.interior_cnt = s1_q.interior_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      abs_sum_q    <= '0;
      square_sum_q <= '0;
      largest_q    <= '0;
      masked_q     <= '0;
    end else begin
      if (q_rd_o) begin
        s1_valid_q <= 1'b1;
      end else if (consume) begin
        s1_valid_q <= 1'b0;
      end
      if (consume) begin
        if (s1_q.last) begin
          abs_sum_q    <= '0;
          square_sum_q <= '0;
          largest_q    <= '0;
          masked_q     <= '0;
        end else begin
          abs_sum_q    <= next.abs_sum;
          square_sum_q <= next.square_sum;
          largest_q    <= next.largest_abs;
          masked_q     <= next.masked_count;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      s1_q <= q_data_i;
      sq_q <= sq_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/enorm_final.sv -----
// Closing unit: two bit-serial dividers, a bit-serial square root, result register.
// Depends on enorm_pkg.
`default_nettype none

module enorm_final (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire enorm_pkg::snap_t   snap_i,
  output logic                    idle_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output enorm_pkg::out_item_t    result_o
);
  import enorm_pkg::*;

  localparam int unsigned IterW = $clog2(SqW);
  localparam int unsigned RemRW = DataW + 1;

  fin_state_e state_q, state_d;

  logic [SqW-1:0]    num_a_q, num_a_d, num_b_q, num_b_d;
  logic [CountW-1:0] den_a_q, den_a_d, den_b_q, den_b_d;
  logic [CountW-1:0] rem_a_q, rem_a_d, rem_b_q, rem_b_d;
  logic [DataW-1:0]  root_q, root_d;
  logic [RemRW-1:0]  rem_r_q, rem_r_d;
  logic [IterW-1:0]  iter_q, iter_d;
  logic [DiffW-1:0]  largest_q, largest_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [CountW:0]   ra_sh, rb_sh;
  logic              ge_a, ge_b, ge_r;
  logic [RemRW+1:0]  rr_sh, trial;

  assign idle_o   = state_q == FinIdle;
  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  always_comb begin
    state_d     = state_q;
    num_a_d     = num_a_q;
    num_b_d     = num_b_q;
    den_a_d     = den_a_q;
    den_b_d     = den_b_q;
    rem_a_d     = rem_a_q;
    rem_b_d     = rem_b_q;
    root_d      = root_q;
    rem_r_d     = rem_r_q;
    iter_d      = iter_q;
    largest_d   = largest_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;

    // Restoring division step; the quotient shifts into the dividend register.
    ra_sh = {rem_a_q, num_a_q[SqW-1]};
    rb_sh = {rem_b_q, num_b_q[SqW-1]};
    ge_a  = ra_sh >= {1'b0, den_a_q};
    ge_b  = rb_sh >= {1'b0, den_b_q};

    // Square root step, two radicand bits at a time.
    rr_sh = {rem_r_q, num_b_q[SqW-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    ge_r  = rr_sh >= trial;

    unique case (state_q)
      FinIdle: begin
        if (start_i) begin
          num_a_d   = SqW'(snap_i.abs_sum);
          den_a_d   = snap_i.masked_count;
          num_b_d   = snap_i.square_sum;
          den_b_d   = snap_i.interior_cnt;
          largest_d = snap_i.largest_abs;
          rem_a_d   = '0;
          rem_b_d   = '0;
          iter_d    = '0;
          state_d   = FinDivide;
        end
      end
      FinDivide: begin
        rem_a_d = ge_a ? CountW'(ra_sh - {1'b0, den_a_q}) : CountW'(ra_sh);
        rem_b_d = ge_b ? CountW'(rb_sh - {1'b0, den_b_q}) : CountW'(rb_sh);
        num_a_d = {num_a_q[SqW-2:0], ge_a};
        num_b_d = {num_b_q[SqW-2:0], ge_b};
        iter_d  = iter_q + IterW'(1);
        if (iter_q == IterW'(SqW - 1)) begin
          root_d  = '0;
          rem_r_d = '0;
          iter_d  = '0;
          state_d = FinRoot;
        end
      end
      FinRoot: begin
        rem_r_d = ge_r ? RemRW'(rr_sh - trial) : RemRW'(rr_sh);
        root_d  = {root_q[DataW-2:0], ge_r};
        num_b_d = {num_b_q[SqW-3:0], 2'b00};
        iter_d  = iter_q + IterW'(1);
        if (iter_q == IterW'(DataW - 1)) begin
          state_d = FinDone;
        end
      end
      FinDone: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || pop_i) begin
          out_d.mean_abs_error    = (den_a_q == '0) ? '0 :
                                    ((num_a_q[SqW-1:DataW] != '0) ? '1 : num_a_q[DataW-1:0]);
          out_d.rms_error         = (den_b_q == '0) ? '0 : root_q;
          out_d.max_abs_error     = largest_q[DiffW-1] ? '1 : largest_q[DataW-1:0];
          out_d.masked_cells      = den_a_q;
          out_d.no_masked_cells   = den_a_q == '0;
          out_d.no_interior_cells = den_b_q == '0;
          out_valid_d             = 1'b1;
          state_d                 = FinIdle;
        end
      end
      default: state_d = FinIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FinIdle;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_a_q   <= num_a_d;
    num_b_q   <= num_b_d;
    den_a_q   <= den_a_d;
    den_b_q   <= den_b_d;
    rem_a_q   <= rem_a_d;
    rem_b_q   <= rem_b_d;
    root_q    <= root_d;
    rem_r_q   <= rem_r_d;
    largest_q <= largest_d;
    out_q     <= out_d;
  end

endmodule

`default_nettype wire

// ----- rtl/error_norm_accumulator.sv -----
// L1 / L2 / Linf error norms over a streamed grid; top level built from enorm_front,
// enorm_fifo, enorm_back and enorm_final, types from enorm_pkg.
// Throughput: one cell per cycle; the last cell of a run holds in the back while the
// closing unit is busy on the previous run, and longer while its result waits.
// Last cell's path: queue, square, accumulate, 64 divide steps, 32 root steps, output.
// Reset clears control state and accumulators; registers take defaults.
`default_nettype none

module error_norm_accumulator #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Cell input, queue style
  input  wire logic                           push,
  output logic                                full,
  input  wire enorm_pkg::in_item_t            item_i,
  // Result output, queue style
  output logic                                empty,
  input  wire logic                           pop,
  output enorm_pkg::out_item_t                result_o,
  // Configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [enorm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [enorm_pkg::DataW-1:0]    cfg_data_i
);
  import enorm_pkg::*;

  logic   q_full, q_nonempty, q_rd, accept;
  cell_t  front_cell, q_cell;
  logic   fin_idle, fin_start;
  snap_t  snap;

  // Registers are plain flops; accept every write at once.
  assign cfg_ready_o = 1'b1;

  // Accept a request whenever the queue has room, even while a result waits.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Classify each cell against the current run settings and advance the index.
  enorm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (item_i),
    .cell_o      (front_cell)
  );

  // Decouple the front from a back that stalls on the last cell of a run.
  enorm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept),
    .wr_data_i  (front_cell),
    .full_o     (q_full),
    .rd_i       (q_rd),
    .rd_data_o  (q_cell),
    .nonempty_o (q_nonempty)
  );

  // Square and accumulate; snapshot and clear on the last cell.
  enorm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (q_nonempty),
    .q_data_i     (q_cell),
    .q_rd_o       (q_rd),
    .fin_idle_i   (fin_idle),
    .start_o      (fin_start),
    .snap_o       (snap)
  );

  // Divide, take the root and hold the result for the consumer.
  enorm_final u_final (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (fin_start),
    .snap_i   (snap),
    .idle_o   (fin_idle),
    .empty_o  (empty),
    .pop_i    (pop),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ----- rtl/enorm_checker.sv -----
// Port-level checks on the error norm accumulator results, bound to the top level.
// Depends on enorm_pkg and error_norm_accumulator.
`default_nettype none

module enorm_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire enorm_pkg::out_item_t result_o
);
  import enorm_pkg::*;

  // Hold a waiting result until it is taken.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed or vanished while waiting");

  a_masked_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.no_masked_cells == (result_o.masked_cells == '0)))
    else $error("empty masked flag disagrees with masked count");

  a_empty_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.no_masked_cells) |->
      (result_o.mean_abs_error == '0 && result_o.max_abs_error == '0))
    else $error("L1 or Linf nonzero over an empty masked set");

  // A count change mid-run may leave masked cells behind, so check only L2 here.
  a_empty_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.no_interior_cells) |-> (result_o.rms_error == '0))
    else $error("L2 nonzero over an empty interior");

  a_mean_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.mean_abs_error <= result_o.max_abs_error))
    else $error("mean absolute error exceeds the maximum");

endmodule

bind error_norm_accumulator enorm_checker u_enorm_checker (.*);

`default_nettype wire

// ----- dv/error_norm_accumulator_tb.sv -----
// Self-checking testbench for error_norm_accumulator: directed rows, then random grid runs.
// Expected norms: in-bench L1 / L2 / Linf predictor, or typed in on some directed rows.
// Depends on enorm_pkg for the item, result and register index types.
`timescale 1ns / 100ps

module error_norm_accumulator_tb;
  import enorm_pkg::*;

  // Wait at the end of a drain so the block runs dry, with some margin on top.
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned RandomCells = 1800;
  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned NoCut       = 32'hFFFF_FFFF;
  localparam logic [49:0] AbsSumMax   = (50'd1 << AbsSumW) - 50'd1;

  typedef enum logic {
    RowWrite,
    RowCell
  } row_kind_e;

  // One row of the directed table: a register write or a cell, with an
  // optional typed-in result for the cell that closes a run.
  typedef struct packed {
    row_kind_e   kind;
    cfg_idx_e    reg_sel;
    logic [31:0] wdata;
    in_item_t    item;
    logic        typed;
    out_item_t   want;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  in_item_t    item_i      = '0;
  logic        empty;
  logic        pop         = 1'b0;
  out_item_t   result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i = CfgCellCount;
  logic [31:0] cfg_data_i  = '0;

  // Predictor copy of the register file (reset values).
  logic [16:0] reg_cells     = 17'd1;
  logic [14:0] reg_skip      = '0;
  logic        reg_radius_on = 1'b0;
  logic [31:0] reg_radius    = 32'hFFFF_FFFF;

  // Predictor copy of the run accumulators.
  logic [16:0] acc_index  = '0;
  logic [63:0] acc_square = '0;
  logic [48:0] acc_abs    = '0;
  logic [32:0] acc_peak   = '0;
  logic [16:0] acc_hits   = '0;

  out_item_t   expected_norms[$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned random_cells = 0;
  int unsigned burst_left   = 0;
  int unsigned on_left      = 0;
  int unsigned off_left     = 0;
  bit          run_closed;

  always #5 clk_i = ~clk_i;

  error_norm_accumulator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Floor of the square root, built one result bit at a time from the top.
  function automatic logic [31:0] root_floor(logic [63:0] v);
    logic [31:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = {32'd0, r | (32'd1 << b)};
      if (t * t <= v) r = r | (32'd1 << b);
    end
    return r;
  endfunction

  // Fold one cell into the run; on the closing cell return 1 with the norms
  // and clear the run.
  function automatic bit accumulate_cell(input in_item_t c, output out_item_t norms);
    logic [17:0] span;
    logic [17:0] twice_skip;
    logic [17:0] inner_cnt;
    logic [32:0] diff_mag;
    logic [32:0] pos_mag;
    logic [63:0] square;
    logic [64:0] square_wide;
    logic [49:0] abs_wide;
    logic [48:0] mean_wide;
    logic        inner;
    logic        passes;
    norms = '0;
    // Clamp the run length to 1 .. MaxCells.
    span = {1'b0, reg_cells};
    if (span == 0) span = 18'd1;
    if (span > MaxCells) span = 18'(MaxCells);

    // Exact 33-bit difference and position magnitudes.
    diff_mag = {c.reference_value[31], c.reference_value}
             - {c.computed_value[31], c.computed_value};
    if (diff_mag[32]) diff_mag = -diff_mag;
    pos_mag = {c.position[31], c.position};
    if (pos_mag[32]) pos_mag = -pos_mag;

    inner  = (acc_index >= reg_skip) && (18'(acc_index) + 18'(reg_skip) < span);
    passes = !reg_radius_on || (pos_mag < {1'b0, reg_radius});

    if (inner) begin
      square = (diff_mag > 33'h0_FFFF_FFFF) ? '1 : {31'd0, diff_mag} * {31'd0, diff_mag};
      square_wide = {1'b0, acc_square} + {1'b0, square};
      acc_square = square_wide[64] ? '1 : square_wide[63:0];
      if (passes) begin
        abs_wide = {1'b0, acc_abs} + 50'(diff_mag);
        acc_abs = (abs_wide > AbsSumMax) ? AbsSumMax[48:0] : abs_wide[48:0];
        if (diff_mag > acc_peak) acc_peak = diff_mag;
        if (acc_hits != '1) acc_hits++;
      end
    end

    // Any index at or past the end closes the run, also after a count change.
    if (18'(acc_index) < span - 18'd1) begin
      acc_index++;
      return 1'b0;
    end

    twice_skip = 18'(reg_skip) << 1;
    inner_cnt  = (span > twice_skip) ? span - twice_skip : '0;
    if (acc_hits != 0) begin
      mean_wide = acc_abs / acc_hits;
      norms.mean_abs_error = (mean_wide > 49'h0_FFFF_FFFF) ? '1 : mean_wide[31:0];
    end
    if (inner_cnt != 0) norms.rms_error = root_floor(acc_square / inner_cnt);
    norms.max_abs_error     = acc_peak[32] ? '1 : acc_peak[31:0];
    norms.masked_cells      = acc_hits;
    norms.no_masked_cells   = (acc_hits == 0);
    norms.no_interior_cells = (inner_cnt == 0);

    acc_index  = '0;
    acc_square = '0;
    acc_abs    = '0;
    acc_peak   = '0;
    acc_hits   = '0;
    return 1'b1;
  endfunction

  function automatic stim_row_t reg_row(cfg_idx_e sel, logic [31:0] value);
    stim_row_t r;
    r = '0;
    r.kind    = RowWrite;
    r.reg_sel = sel;
    r.wdata   = value;
    return r;
  endfunction

  function automatic stim_row_t cell_row(logic [31:0] pos, logic [31:0] exact,
                                         logic [31:0] approx, logic typed = 1'b0,
                                         out_item_t want = '0);
    stim_row_t r;
    r = '0;
    r.kind                 = RowCell;
    r.item.position        = pos;
    r.item.reference_value = exact;
    r.item.computed_value  = approx;
    r.typed                = typed;
    r.want                 = want;
    return r;
  endfunction

  // Random cell: positions are random, near the radius edge, at the extremes or near zero;
  // values are close pairs, full-range pairs, equal pairs or extreme differences.
  function automatic in_item_t rand_cell();
    in_item_t    c;
    logic [31:0] span;
    case ($urandom_range(0, 3))
      0: c.position = $urandom;
      1: begin
        span = reg_radius + 32'($urandom_range(0, 2)) - 32'd1;
        c.position = $urandom_range(0, 1) ? span : -span;
      end
      2: c.position = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: c.position = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    endcase
    c.reference_value = $urandom;
    case ($urandom_range(0, 4))
      0, 1: c.computed_value = c.reference_value
                             + (32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000);
      2: c.computed_value = $urandom;
      3: c.computed_value = c.reference_value;
      default: begin
        c.reference_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        c.computed_value  = ~c.reference_value;
      end
    endcase
    return c;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Hold the cell port idle; n >= 1.
  task automatic hold_off(int unsigned n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop push and wait until every expected result has been taken, then let
  // the pipeline run dry of cells that close no run.
  task automatic drain();
    push <= 1'b0;
    while (expected_norms.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offer one cell and hold it until accepted; push stays high on return so
  // a following cell goes out back to back.
  task automatic send_cell(in_item_t c, logic typed, out_item_t want);
    out_item_t norms;
    push   <= 1'b1;
    item_i <= c;
    do @(posedge clk_i); while (full);
    run_closed = accumulate_cell(c, norms);
    if (run_closed) expected_norms.push_back(typed ? want : norms);
  endtask

  // Register writes only go out on an idle block.
  task automatic write_reg(cfg_idx_e sel, logic [31:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (sel)
      CfgCellCount:    reg_cells     = value[16:0];
      CfgBoundarySkip: reg_skip      = value[14:0];
      CfgRadiusEnable: reg_radius_on = value[0];
      CfgRadiusLimit:  reg_radius    = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Sender pacing: bursts of random length, sometimes long ones with no gap.
  task automatic pace();
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      hold_off($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 20);
    end
  endtask

  // Low bits carry the value; upper bits sometimes carry junk the block drops.
  function automatic logic [31:0] with_junk(logic [31:0] value, int unsigned bits);
    if ($urandom_range(0, 3) != 0) return value;
    return value | ($urandom & ~((32'd1 << bits) - 32'd1));
  endfunction

  // New random register setting for a phase; returns 1 for a run length too
  // long to play out, which the caller cuts short.
  task automatic new_settings(output bit big);
    logic [16:0] cells;
    logic [14:0] skip;
    logic [31:0] lim;
    big = 1'b0;
    case ($urandom_range(0, 9))
      0: begin
        cells = 17'd1;
        skip  = '0;
      end
      1: begin
        cells = '0;
        skip  = 15'($urandom_range(0, 1));
      end
      2: begin
        cells = 17'($urandom_range(2, 30));
        skip  = 15'($urandom_range(cells / 2, cells));
      end
      3: begin
        cells = 17'($urandom_range(1, 20));
        skip  = 15'h7FFF;
      end
      4: begin
        cells = $urandom_range(0, 1) ? 17'h1_FFFF : 17'h1_0000;
        skip  = $urandom_range(0, 1) ? 15'h7FFF : 15'($urandom_range(0, 40));
        big   = 1'b1;
      end
      default: begin
        cells = 17'($urandom_range(2, 48));
        skip  = 15'($urandom_range(0, cells / 3));
      end
    endcase
    case ($urandom_range(0, 4))
      0:       lim = '0;
      1:       lim = '1;
      2:       lim = $urandom;
      3:       lim = 32'h8000_0000;
      default: lim = $urandom_range(0, 32'h0003_0000);
    endcase
    write_reg(CfgCellCount, with_junk(32'(cells), 17));
    write_reg(CfgBoundarySkip, with_junk(32'(skip), 15));
    write_reg(CfgRadiusEnable, with_junk(32'($urandom_range(0, 1)), 1));
    write_reg(CfgRadiusLimit, lim);
  endtask

  // Play cells until a run closes; after cut_at cells, rewrite the count
  // mid-run so the run ends early or late.
  task automatic run_cells(int unsigned cut_at);
    int unsigned sent;
    sent = 0;
    run_closed = 1'b0;
    while (!run_closed) begin
      if (sent == cut_at) write_reg(CfgCellCount, 32'($urandom_range(0, 48)));
      send_cell(rand_cell(), 1'b0, '0);
      random_cells++;
      sent++;
      pace();
    end
  endtask

  // Result side: check each accepted result against the oldest expectation,
  // then pick the next pop value from an on/off stall pattern.
  always @(posedge clk_i) begin : result_side
    out_item_t want;
    logic      pop_next;
    if (pop && !empty) begin
      if (expected_norms.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %p",
                 $time, result_o);
        mismatches++;
      end else begin
        want = expected_norms.pop_front();
        check_field("mean_abs_error", want.mean_abs_error, result_o.mean_abs_error);
        check_field("rms_error", want.rms_error, result_o.rms_error);
        check_field("max_abs_error", want.max_abs_error, result_o.max_abs_error);
        check_field("masked_cells", 32'(want.masked_cells), 32'(result_o.masked_cells));
        check_field("no_masked_cells", 32'(want.no_masked_cells),
                    32'(result_o.no_masked_cells));
        check_field("no_interior_cells", 32'(want.no_interior_cells),
                    32'(result_o.no_interior_cells));
      end
    end
    if (on_left != 0) begin
      pop_next = 1'b1;
      on_left--;
    end else if (off_left != 0) begin
      pop_next = 1'b0;
      off_left--;
    end else begin
      on_left  = $urandom_range(1, 40);
      off_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      pop_next = 1'b1;
    end
    pop <= rst_ni ? pop_next : 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t plan[$];
    bit        big;

    // Reset state: one cell per run, no skip, no radius limit.
    plan.push_back(cell_row(32'h0, 32'h0, 32'h0, 1'b1,
                            out_item_t'{32'h0, 32'h0, 32'h0, 17'd1, 1'b0, 1'b0}));
    // Largest difference in either direction, extreme positions.
    plan.push_back(cell_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                            out_item_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        17'd1, 1'b0, 1'b0}));
    plan.push_back(cell_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                            out_item_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        17'd1, 1'b0, 1'b0}));
    // A difference of exactly 1.0.
    plan.push_back(cell_row(32'hFFFF_0000, 32'h0001_0000, 32'h0, 1'b1,
                            out_item_t'{32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                        17'd1, 1'b0, 1'b0}));
    // Radius limit of zero with the limit on: nothing passes, RMS still counts.
    plan.push_back(reg_row(CfgRadiusEnable, 32'd1));
    plan.push_back(reg_row(CfgRadiusLimit, 32'd0));
    plan.push_back(cell_row(32'h0, 32'd5, 32'd2, 1'b1,
                            out_item_t'{32'h0, 32'd3, 32'h0, 17'd0, 1'b1, 1'b0}));
    // Four cells, one boundary cell per end, radius 2.0 with the strict edge hit.
    plan.push_back(reg_row(CfgRadiusLimit, 32'h0002_0000));
    plan.push_back(reg_row(CfgCellCount, 32'd4));
    plan.push_back(reg_row(CfgBoundarySkip, 32'd1));
    plan.push_back(cell_row(32'hFFFE_0000, 32'h0000_0100, 32'h0));
    plan.push_back(cell_row(32'h0002_0000, 32'h0003_0000, 32'h0001_0000));
    plan.push_back(cell_row(32'hFFFE_0001, 32'h1234_5678, 32'hEDCB_A987));
    plan.push_back(cell_row(32'h0, 32'd1, 32'd2));
    // Skip covers the whole grid: empty interior.
    plan.push_back(reg_row(CfgBoundarySkip, 32'd2));
    plan.push_back(cell_row(32'h0, 32'd7, 32'd1));
    plan.push_back(cell_row(32'h0, 32'h7FFF_FFFF, 32'h0));
    plan.push_back(cell_row(32'h0, 32'd0, 32'd9));
    plan.push_back(cell_row(32'h0, 32'd3, 32'd3, 1'b1,
                            out_item_t'{32'h0, 32'h0, 32'h0, 17'd0, 1'b1, 1'b1}));
    // Count of zero runs as one; largest skip leaves no interior.
    plan.push_back(reg_row(CfgBoundarySkip, 32'h7FFF));
    plan.push_back(reg_row(CfgCellCount, 32'd0));
    plan.push_back(cell_row(32'h0, 32'd100, 32'd1, 1'b1,
                            out_item_t'{32'h0, 32'h0, 32'h0, 17'd0, 1'b1, 1'b1}));
    plan.push_back(reg_row(CfgBoundarySkip, 32'd0));
    plan.push_back(reg_row(CfgRadiusEnable, 32'd0));
    plan.push_back(cell_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                            out_item_t'{32'h0, 32'h0, 32'h0, 17'd1, 1'b0, 1'b0}));
    // Count lowered mid-run to the current index: next cell closes the run.
    plan.push_back(reg_row(CfgCellCount, 32'd3));
    plan.push_back(cell_row(32'h0001_0000, 32'h0000_8000, 32'h0));
    plan.push_back(cell_row(32'hFFFF_8000, 32'h0, 32'h0004_0000));
    plan.push_back(reg_row(CfgCellCount, 32'd2));
    plan.push_back(cell_row(32'h0, 32'h0002_0000, 32'h0001_0000));
    // Widest radius with the limit on: the most negative position still passes.
    plan.push_back(reg_row(CfgRadiusLimit, 32'hFFFF_FFFF));
    plan.push_back(reg_row(CfgRadiusEnable, 32'd1));
    plan.push_back(cell_row(32'h8000_0000, 32'h0000_1234, 32'hFFFF_0000));
    plan.push_back(cell_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        write_reg(plan[i].reg_sel, plan[i].wdata);
      end else begin
        send_cell(plan[i].item, plan[i].typed, plan[i].want);
        pace();
      end
    end

    // Random phases: each one drains the block, writes a fresh setting and
    // plays whole runs, some of them cut by a mid-run count change.
    while (random_cells < RandomCells) begin
      new_settings(big);
      if (big) begin
        run_cells($urandom_range(3, 60));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          run_cells(($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : NoCut);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/enorm_pkg.sv
rtl/enorm_front.sv
rtl/enorm_fifo.sv
rtl/enorm_back.sv
rtl/enorm_final.sv
rtl/error_norm_accumulator.sv
rtl/enorm_checker.sv
dv/error_norm_accumulator_tb.sv
